// File: rtl/crc_rc_pkg.sv
// Shared types and constants for the CRC-32 framed record checker.
// No dependencies.
package crc_rc_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned MAGIC_BYTES = 8;
  localparam int unsigned LEN_END = 12;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int unsigned LEN_W = 13;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 13'd4096;

  // One result word as it leaves the checker.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             verdict_ready;
    logic             record_status;
    logic [LEN_W-1:0] payload_length;
  } res_t;

  // Expected byte of the 8-byte ASCII magic tag at a given place.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h34;
      3'd1: b = 8'h56;
      3'd2: b = 8'h52;
      3'd3: b = 8'h53;
      3'd4: b = 8'h4E;
      3'd5: b = 8'h45;
      3'd6: b = 8'h54;
      3'd7: b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/crc_rc_crc_step.sv
// Byte-wide reflected CRC-32 update, unrolled into combinational XOR logic.
// Depends on crc_rc_pkg.
module crc_rc_crc_step (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);
  import crc_rc_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_o = c;
  end

endmodule

// File: rtl/crc_rc_frame.sv
// Record framing state: position counter, header capture, running CRC and verdict.
// Depends on crc_rc_pkg and crc_rc_crc_step.
module crc_rc_frame #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           end_of_record_i,
  input  logic [crc_rc_pkg::LEN_W-1:0]   length_limit_i,
  output crc_rc_pkg::res_t               res_o
);
  import crc_rc_pkg::*;

  // Counter saturates above the last payload place, so comparisons stay exact.
  localparam int unsigned PW = $clog2(MAX_LEN + HDR_BYTES + 2);
  localparam logic [PW-1:0] POS_SAT = {PW{1'b1}};

  logic [PW-1:0] pos_q, pos_d;
  logic          magic_q, magic_d;
  logic [31:0]   len_q, len_d;
  logic [31:0]   chk_q, chk_d;
  logic [31:0]   crc_q, crc_d;
  logic [31:0]   crc_next;

  logic          in_magic, in_len, in_chk, in_body;
  logic          hdr_ok, fwd, rec_ok;
  logic [PW-1:0] pidx;
  logic [31:0]   crc_used;

  crc_rc_crc_step u_crc (
    .crc_i  (crc_q),
    .data_i (data_byte_i),
    .crc_o  (crc_next)
  );

  assign in_magic = pos_q < PW'(MAGIC_BYTES);
  assign in_len   = !in_magic && (pos_q < PW'(LEN_END));
  assign in_chk   = !in_magic && !in_len && (pos_q < PW'(HDR_BYTES));
  assign in_body  = !(pos_q < PW'(HDR_BYTES));
  assign pidx     = pos_q - PW'(HDR_BYTES);

  assign hdr_ok = magic_q && (len_q != 32'd0) && (len_q <= 32'(MAX_LEN))
                  && (len_q <= 32'(length_limit_i));
  assign fwd      = in_body && hdr_ok && (32'(pidx) < len_q);
  assign crc_used = fwd ? crc_next : crc_q;
  assign rec_ok   = end_of_record_i && in_body && hdr_ok
                    && (32'(pidx) == (len_q - 32'd1))
                    && (chk_q == ~crc_used);

  always_comb begin
    res_o.payload_byte   = fwd ? data_byte_i : 8'd0;
    res_o.payload_valid  = fwd;
    res_o.verdict_ready  = end_of_record_i;
    res_o.record_status  = end_of_record_i && !rec_ok;
    res_o.payload_length = rec_ok ? len_q[LEN_W-1:0] : '0;
  end

  always_comb begin
    pos_d   = pos_q;
    magic_d = magic_q;
    len_d   = len_q;
    chk_d   = chk_q;
    crc_d   = crc_q;
    if (push_i) begin
      if (end_of_record_i) begin
        pos_d   = '0;
        magic_d = 1'b1;
        len_d   = '0;
        chk_d   = '0;
        crc_d   = CRC_INIT;
      end else begin
        if (pos_q != POS_SAT) begin
          pos_d = pos_q + PW'(1);
        end
        if (in_magic && (data_byte_i != magic_byte(pos_q[2:0]))) begin
          magic_d = 1'b0;
        end
        if (in_len) begin
          len_d = {len_q[23:0], data_byte_i};
        end
        if (in_chk) begin
          chk_d = {chk_q[23:0], data_byte_i};
        end
        crc_d = crc_used;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= 1'b1;
      len_q   <= '0;
      chk_q   <= '0;
      crc_q   <= CRC_INIT;
    end else begin
      pos_q   <= pos_d;
      magic_q <= magic_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// File: rtl/crc_rc_out_buf.sv
// Two-word result buffer: output register plus skid register.
// Depends on crc_rc_pkg.
module crc_rc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crc_rc_pkg::res_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output crc_rc_pkg::res_t res_o
);
  import crc_rc_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: rtl/crc32_record_checker.sv
// CRC-32 framed record checker, top level.
// Depends on crc_rc_pkg, crc_rc_frame, crc_rc_crc_step and crc_rc_out_buf.
//
// Checks one stored record per run of words, one byte to a word, the final
// byte flagged with end_of_record_i. Bytes 0-7 must match the 8-byte magic,
// bytes 8-11 carry the payload length big-endian (nonzero, at most MAX_LEN
// and at most the length_limit register), bytes 12-15 carry the reflected
// CRC-32 of the payload big-endian. Every accepted byte yields exactly one
// result word; payload bytes are flagged and forwarded as they arrive, and
// the word for the final byte carries the verdict (record_status_o 0 valid,
// 1 invalid) and, on a valid record, its length. Short records, trailing
// bytes, bad magic, bad length and CRC mismatch all give invalid, and the
// consumer should drop forwarded bytes then. After the final byte the
// checker starts afresh. Throughput is one byte per clock unless the output
// buffer is full; the byte-wide CRC update is combinational XOR logic and
// the result word is registered in the output or skid register. A two-word
// output buffer lets the input keep flowing for one more word while the
// consumer stalls. The user must write length_limit through cfg_we_i /
// cfg_wdata_i only while the checker is idle (not enforced); reset value 4096.
module crc32_record_checker #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [crc_rc_pkg::LEN_W-1:0] cfg_wdata_i,
  // byte input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_record_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   payload_byte_o,
  output logic                         payload_valid_o,
  output logic                         verdict_ready_o,
  output logic                         record_status_o,
  output logic [crc_rc_pkg::LEN_W-1:0] payload_length_o
);
  import crc_rc_pkg::*;

  logic [LEN_W-1:0] limit_q;
  logic             push;
  logic             buf_full;
  res_t             res_new;
  res_t             res_out;

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !buf_full;
  assign push       = in_valid_i && in_ready_o;

  crc_rc_frame #(
    .MAX_LEN (MAX_LEN)
  ) u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .end_of_record_i (end_of_record_i),
    .length_limit_i  (limit_q),
    .res_o           (res_new)
  );

  crc_rc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_new),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign payload_byte_o   = res_out.payload_byte;
  assign payload_valid_o  = res_out.payload_valid;
  assign verdict_ready_o  = res_out.verdict_ready;
  assign record_status_o  = res_out.record_status;
  assign payload_length_o = res_out.payload_length;

endmodule

// File: sim/crc32_record_checker_tb.sv
// Self-checking testbench for crc32_record_checker: framed records in, one result word per byte.
// Depends on crc_rc_pkg and the crc32_record_checker RTL; needs nothing else.
`timescale 1ns / 100ps

localparam int unsigned MAX_PAYLOAD = 4096;
localparam logic [63:0] MAGIC_TAG   = 64'h3456_5253_4E45_5431;

// Byte-wide reflected CRC-32 update, shared by the record builder and the predictor.
function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
  logic [31:0] r;
  r = c ^ {24'd0, b};
  for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? crc_rc_pkg::CRC_POLY : 32'd0);
  return r;
endfunction

// Tracks the checker's view of the current record and the result words still owed.
class crc_record_board;
  logic [crc_rc_pkg::LEN_W-1:0] length_limit;
  logic [31:0]                  byte_pos;
  logic                         magic_ok;
  logic [31:0]                  decl_len;
  logic [31:0]                  stored_crc;
  logic [31:0]                  run_crc;
  crc_rc_pkg::res_t             due_words[$];
  int unsigned                  mismatches;

  function new();
    length_limit = crc_rc_pkg::LIMIT_RESET;
    mismatches   = 0;
    clear_record();
  endfunction

  function void clear_record();
    byte_pos   = '0;
    magic_ok   = 1'b1;
    decl_len   = '0;
    stored_crc = '0;
    run_crc    = crc_rc_pkg::CRC_INIT;
  endfunction

  function void set_limit(input logic [crc_rc_pkg::LEN_W-1:0] v);
    length_limit = v;
  endfunction

  function bit header_good();
    return magic_ok && decl_len != 0 && decl_len <= MAX_PAYLOAD &&
           decl_len <= 32'(length_limit);
  endfunction

  function int unsigned outstanding();
    return due_words.size();
  endfunction

  // Accepted input byte: advance the record state and queue the word it owes.
  function void take_byte(input logic [7:0] d, input logic last);
    crc_rc_pkg::res_t w;
    logic [31:0]      pos;
    logic             fwd;
    logic             good;
    pos  = byte_pos;
    fwd  = 1'b0;
    good = 1'b0;
    if (pos < crc_rc_pkg::MAGIC_BYTES) begin
      if (d != MAGIC_TAG[63 - 8 * pos[2:0] -: 8]) magic_ok = 1'b0;
    end else if (pos < crc_rc_pkg::LEN_END) begin
      decl_len = {decl_len[23:0], d};
    end else if (pos < crc_rc_pkg::HDR_BYTES) begin
      stored_crc = {stored_crc[23:0], d};
    end else if (header_good() && pos - crc_rc_pkg::HDR_BYTES < decl_len) begin
      fwd     = 1'b1;
      run_crc = crc_step(run_crc, d);
    end
    if (last) begin
      good = pos >= crc_rc_pkg::HDR_BYTES && header_good() &&
             pos - crc_rc_pkg::HDR_BYTES == decl_len - 1 &&
             stored_crc == ~run_crc;
    end
    w.payload_byte   = fwd ? d : 8'd0;
    w.payload_valid  = fwd;
    w.verdict_ready  = last;
    w.record_status  = last && !good;
    w.payload_length = good ? decl_len[crc_rc_pkg::LEN_W-1:0] : '0;
    due_words.push_back(w);
    if (last) clear_record();
    else if (byte_pos != '1) byte_pos++;
  endfunction

  function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch, %s: expected %0h, got %0h", what, want, got);
  endfunction

  // Accepted result word: compare with the oldest word owed.
  function void check_word(input crc_rc_pkg::res_t got);
    crc_rc_pkg::res_t want;
    if (due_words.size() == 0) begin
      flag("word with nothing owed", '0, 32'(got));
      return;
    end
    want = due_words.pop_front();
    if (got.payload_byte !== want.payload_byte)
      flag("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    if (got.payload_valid !== want.payload_valid)
      flag("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
    if (got.verdict_ready !== want.verdict_ready)
      flag("verdict_ready", 32'(want.verdict_ready), 32'(got.verdict_ready));
    if (got.record_status !== want.record_status)
      flag("record_status", 32'(want.record_status), 32'(got.record_status));
    if (got.payload_length !== want.payload_length)
      flag("payload_length", 32'(want.payload_length), 32'(got.payload_length));
  endfunction
endclass

module crc32_record_checker_tb;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int unsigned LATENCY_PAD = 4;     // settle time once nothing is owed
  localparam int unsigned PHASE_BYTES = 210;   // random bytes per register setting
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off

  typedef enum {
    REC_GOOD, REC_BAD_CRC, REC_BAD_MAGIC, REC_BAD_LEN, REC_SHORT, REC_TRAILING, REC_NOISE
  } rec_kind_e;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [crc_rc_pkg::LEN_W-1:0] cfg_wdata_i     = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic [7:0]                   data_byte_i     = '0;
  logic                         end_of_record_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic [7:0]                   payload_byte_o;
  logic                         payload_valid_o;
  logic                         verdict_ready_o;
  logic                         record_status_o;
  logic [crc_rc_pkg::LEN_W-1:0] payload_length_o;

  crc_record_board              board = new();
  logic [7:0]                   rec_q[$];      // bytes of the record being sent
  logic [crc_rc_pkg::LEN_W-1:0] cur_limit     = crc_rc_pkg::LIMIT_RESET;
  int unsigned                  send_idle_pct = 23;
  int unsigned                  recv_idle_pct = 51;
  int unsigned                  bytes_sent    = 0;
  int unsigned                  hold_len      = 0;  // written by the stimulus only
  int unsigned                  hold_seen     = 0;  // receiver's own copy
  int unsigned                  hold_count    = 0;
  int unsigned                  quiet_cycles  = 0;

  crc32_record_checker #(
    .MAX_LEN(MAX_PAYLOAD)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_record_i (end_of_record_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .verdict_ready_o (verdict_ready_o),
    .record_status_o (record_status_o),
    .payload_length_o(payload_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure, plus a long hold-off on request. The
  // hold-off is counted here so that the stimulus keeps offering bytes.
  always @(posedge clk_i) begin
    if (hold_len != hold_seen) begin
      hold_seen  = hold_len;
      hold_count = hold_len;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog. Everything is sampled at the edge, before any
  // nonblocking update of that edge lands, so the order of processes is moot.
  // The input side is noted first in case a word comes back in the same cycle.
  always @(posedge clk_i) begin : monitor
    crc_rc_pkg::res_t got;
    if (in_valid_i && in_ready_o) board.take_byte(data_byte_i, end_of_record_i);
    if (out_valid_o && out_ready_i) begin
      got.payload_byte   = payload_byte_o;
      got.payload_valid  = payload_valid_o;
      got.verdict_ready  = verdict_ready_o;
      got.record_status  = record_status_o;
      got.payload_length = payload_length_o;
      board.check_word(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** crc32_record_checker: FAILED **");
      $finish;
    end
  end

  // One byte on the input channel; random gaps in front of it. Valid stays up
  // with the byte held until the checker takes it.
  task automatic send_word(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= d;
    end_of_record_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_record();
    foreach (rec_q[i]) send_word(rec_q[i], i == rec_q.size() - 1);
    bytes_sent += rec_q.size();
  endtask

  // Stop offering and wait until every owed word is back. The first edge lets
  // the monitor note the last byte taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [crc_rc_pkg::LEN_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_limit(v);
    cur_limit = v;
  endtask

  // Build a record into rec_q: magic, length field, CRC, payload, then the
  // damage that the kind asks for. fill < 0 gives random payload bytes.
  task automatic build_record(input rec_kind_e kind, input int unsigned plen,
                              input logic [31:0] len_field, input int fill);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [31:0] crc;
    int          k;
    int unsigned cut;
    rec_q.delete();
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 24)) rec_q.push_back(8'($urandom_range(255)));
    end else begin
      for (k = 0; k < 8; k++) rec_q.push_back(MAGIC_TAG[63 - 8 * k -: 8]);
      if (kind == REC_BAD_MAGIC) begin
        k = $urandom_range(7);
        rec_q[k] = rec_q[k] ^ 8'(1 << $urandom_range(7));
      end
      for (k = 3; k >= 0; k--) rec_q.push_back(len_field[8 * k +: 8]);
      crc = crc_rc_pkg::CRC_INIT;
      repeat (plen) begin
        b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        body.push_back(b);
        crc = crc_step(crc, b);
      end
      crc = ~crc;
      if (kind == REC_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
      for (k = 3; k >= 0; k--) rec_q.push_back(crc[8 * k +: 8]);
      foreach (body[i]) rec_q.push_back(body[i]);
      if (kind == REC_SHORT) begin
        cut = $urandom_range(1, rec_q.size() - 1);
        while (rec_q.size() > cut) void'(rec_q.pop_back());
      end
      if (kind == REC_TRAILING) begin
        repeat ($urandom_range(1, 4)) rec_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Mostly well-formed records with random content; the rest broken or noise.
  task automatic random_record();
    int unsigned r;
    int unsigned lim;
    int unsigned hi;
    int unsigned plen;
    logic [31:0] len_field;
    rec_kind_e   kind;
    lim = (32'(cur_limit) > MAX_PAYLOAD) ? MAX_PAYLOAD : 32'(cur_limit);
    hi  = (lim == 0) ? 8 : ((lim < 48) ? lim : 48);
    if (lim != 0 && lim <= 64 && $urandom_range(7) == 0) plen = lim;
    else plen = $urandom_range(1, hi);
    r = $urandom_range(99);
    if (r < 55)      kind = REC_GOOD;
    else if (r < 63) kind = REC_BAD_CRC;
    else if (r < 69) kind = REC_BAD_MAGIC;
    else if (r < 76) kind = REC_BAD_LEN;
    else if (r < 85) kind = REC_SHORT;
    else if (r < 93) kind = REC_TRAILING;
    else             kind = REC_NOISE;
    len_field = plen;
    if (kind == REC_BAD_LEN) begin
      case ($urandom_range(3))
        0:       len_field = '0;
        1:       len_field = lim + 1;
        2:       len_field = 32'(cur_limit) + 1;
        default: len_field = $urandom() | 32'h0000_2000;
      endcase
    end
    build_record(kind, plen, len_field, -1);
    send_record();
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    bit          paused;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed records at the reset limit: shortest and plain payloads,
    // constant-fill extremes, each way a header can fail, bad CRC, short
    // records (one byte, header only, cut at random), trailing bytes, noise.
    build_record(REC_GOOD, 1, 32'd1, 0);          send_record();
    build_record(REC_GOOD, 4, 32'd4, 255);        send_record();
    build_record(REC_GOOD, 3, 32'd3, -1);         send_record();
    build_record(REC_BAD_MAGIC, 2, 32'd2, -1);    send_record();
    build_record(REC_BAD_LEN, 2, 32'd0, -1);      send_record();
    build_record(REC_BAD_LEN, 1, 32'd4097, -1);   send_record();
    build_record(REC_BAD_LEN, 1, '1, -1);         send_record();
    build_record(REC_BAD_CRC, 5, 32'd5, -1);      send_record();
    build_record(REC_SHORT, 6, 32'd6, -1);        send_record();
    rec_q.delete();
    rec_q.push_back(MAGIC_TAG[63:56]);            send_record();
    build_record(REC_GOOD, 3, 32'd3, -1);
    repeat (3) void'(rec_q.pop_back());           send_record();
    build_record(REC_TRAILING, 2, 32'd2, -1);     send_record();
    build_record(REC_NOISE, 0, 32'd0, -1);        send_record();

    // Register extremes: zero rejects everything, one admits a single byte,
    // the top value is still bounded by the payload maximum.
    write_limit('0);
    build_record(REC_GOOD, 1, 32'd1, -1);         send_record();
    write_limit(13'd1);
    build_record(REC_GOOD, 1, 32'd1, -1);         send_record();
    build_record(REC_GOOD, 2, 32'd2, -1);         send_record();
    write_limit('1);
    build_record(REC_BAD_LEN, 2, 32'd4097, -1);   send_record();

    // Random part: two settings per idling profile, receiver-heavy gaps first,
    // then sender-heavy, then none.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0:       write_limit(crc_rc_pkg::LIMIT_RESET);
        1:       write_limit(13'd1);
        2:       write_limit('1);
        3:       write_limit('0);
        4:       write_limit(13'd37);
        default: write_limit(13'($urandom_range(2, 300)));
      endcase
      phase_start = bytes_sent;
      paused      = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        random_record();
        // sender stops mid-phase until every owed word is back
        if (ph == 1 && !paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
        // receiver goes quiet while bytes keep coming: output buffer fills
        // and the input stalls
        if (ph == 4 && hold_len == 0) hold_len = HOLD_CYCLES;
      end
    end

    drain();
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("** crc32_record_checker: PASSED **");
    end else begin
      $display("** crc32_record_checker: FAILED **");
    end
    $finish;
  end

endmodule
